// ===== design/min_tracking_stack_core_defines.svh =====
// ----------------------------------------------------------------------------
// min_tracking_stack_core_defines
// assertion macros shared by the min tracking stack modules
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_CORE_DEFINES_SVH
`define MIN_TRACKING_STACK_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define MTS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("mts assertion failed");

// consequent must hold in the cycle after the antecedent
`define MTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mts assertion failed");

`else

`define MTS_ASSERT(lbl, clk, rstn, prop)
`define MTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and codes of the min tracking stack
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int DATA_W = 32;

    // action codes; the unused code behaves as a peek
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]               status;
        logic                     empty_res;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] popped_value;
    } t_result;

endpackage

`default_nettype wire

// ===== design/mts_store.sv =====
// ----------------------------------------------------------------------------
// mts_store
// entry memory: value and running minimum per entry, one write and one
// registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mts_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]             i_rd_addr,
    output logic      [2*mts_pkg::DATA_W-1:0]         o_rd_data,
    input  wire logic                                 i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]             i_wr_addr,
    input  wire logic [2*mts_pkg::DATA_W-1:0]         i_wr_data
);
    import mts_pkg::*;

    logic [2*DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl
// sequencer and top-of-stack cache: reads the entry below the top on a pop,
// writes pushed entries back to the memory
// ----------------------------------------------------------------------------
`default_nettype none
`include "min_tracking_stack_core_defines.svh"

module mts_ctrl #(
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [1:0]                           i_action,
    input  wire logic signed [mts_pkg::DATA_W-1:0]    i_value,
    output logic                                      o_res_valid,
    input  wire logic                                 i_res_ready,
    output mts_pkg::t_result                          o_res,
    output logic                                      o_rd_en,
    output logic      [$clog2(DEPTH)-1:0]             o_rd_addr,
    input  wire logic [2*mts_pkg::DATA_W-1:0]         i_rd_data,
    output logic                                      o_wr_en,
    output logic      [$clog2(DEPTH)-1:0]             o_wr_addr,
    output logic      [2*mts_pkg::DATA_W-1:0]         o_wr_data
);
    import mts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic signed [DATA_W-1:0] r_top_val, n_top_val;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;
    logic [1:0] r_action;
    logic signed [DATA_W-1:0] r_value;

    logic w_accept;
    logic w_fire;
    logic w_push;
    logic w_empty;
    logic w_full;
    logic [CW-1:0] w_cnt_m2;
    logic signed [DATA_W-1:0] w_push_min;
    t_result w_res;

    assign w_accept = i_valid && o_ready;
    assign w_fire   = (r_state == S_EXEC) && i_res_ready;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == FULL_COUNT);
    assign w_cnt_m2 = r_count - CW'(2);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_res_valid = (r_state == S_EXEC);
    end

    // entry below the top is fetched while the item is taken
    assign o_rd_en   = w_accept && (i_action == ACT_POP) && (r_count > CW'(1));
    assign o_rd_addr = w_cnt_m2[AW-1:0];

    assign w_push_min = (!w_empty && (r_value > r_top_min)) ? r_top_min : r_value;

    always_comb begin
        n_count   = r_count;
        n_top_val = r_top_val;
        n_top_min = r_top_min;
        w_push    = 1'b0;
        w_res     = '0;
        w_res.popped_value = ALL_ONES;
        w_res.status       = ST_OK;
        unique case (r_action)
            ACT_PUSH: begin
                if (w_full) begin
                    w_res.status = ST_OVERFLOW;
                end else begin
                    w_push    = 1'b1;
                    n_count   = r_count + CW'(1);
                    n_top_val = r_value;
                    n_top_min = w_push_min;
                end
            end
            ACT_POP: begin
                if (w_empty) begin
                    w_res.status = ST_UNDERFLOW;
                end else begin
                    w_res.popped_value = r_top_val;
                    n_count = r_count - CW'(1);
                    n_top_val = i_rd_data[DATA_W-1:0];
                    n_top_min = i_rd_data[2*DATA_W-1:DATA_W];
                end
            end
            default: begin
                if (w_empty) begin
                    w_res.status = ST_UNDERFLOW;
                end
            end
        endcase
        if (n_count == '0) begin
            w_res.top_value = ALL_ONES;
            w_res.min_value = ALL_ONES;
            w_res.empty_res = 1'b1;
        end else begin
            w_res.top_value = n_top_val;
            w_res.min_value = n_top_min;
            w_res.empty_res = 1'b0;
        end
    end

    assign o_res     = w_res;
    assign o_wr_en   = w_fire && w_push;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = {w_push_min, r_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (w_fire) begin
            r_top_val <= n_top_val;
            r_top_min <= n_top_min;
        end
    end

    `MTS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT)
    `MTS_ASSERT(a_no_rd_wr_overlap, i_clk, i_rst_n, !(o_rd_en && o_wr_en))
    `MTS_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC)
    `MTS_ASSERT_NEXT(a_count_holds, i_clk, i_rst_n, !w_fire, $stable(r_count))

endmodule

`default_nettype wire

// ===== design/min_tracking_stack_core.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// lifo of signed 32-bit words that also reports the minimum of all entries
//
//   channel  dir  word fields (lsb first)
//   s_axis   in   action[1:0], value[33:2], zero pad to 40 bits
//   m_axis   out  popped_value[31:0], top_value[63:32], min_value[95:64],
//                 empty_res[96], status[98:97], zero pad to 104 bits
//
// each word is taken in the idle state, which also fetches the entry below the
// top from the memory; the exec state updates the top registers and writes back
// the result sits in an output register; a new word is taken while it waits
// a stalled output holds the update cycle until the register frees
// synchronous active-low reset empties the stack; memory is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_core #(
    parameter int DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [39:0]   i_s_axis_tdata,   // action, value
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic      [103:0]  o_m_axis_tdata    // popped, top, min, empty, status
);
    import mts_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                     w_res_valid;
    logic                     w_res_ready;
    t_result                  w_res;
    logic                     w_rd_en;
    logic [AW-1:0]            w_rd_addr;
    logic [2*DATA_W-1:0]      w_rd_data;
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic [2*DATA_W-1:0]      w_wr_data;

    logic    r_out_valid;
    t_result r_out_res;

    assign w_res_ready = !r_out_valid || i_m_axis_tready;

    mts_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (i_s_axis_tdata[1:0]),
        .i_value     (i_s_axis_tdata[33:2]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    mts_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_res.status, r_out_res.empty_res,
                              r_out_res.min_value, r_out_res.top_value,
                              r_out_res.popped_value};

endmodule

`default_nettype wire

// ===== bench/min_tracking_stack_checker.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_checker
// watches both stream channels of the min tracking stack, keeps its own copy
// of the value and minimum columns, and compares every output word field by
// field with the oldest predicted result
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_checker #(
    parameter int DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    input  wire logic          i_s_tready,
    input  wire logic [39:0]   i_s_tdata,    // action, value
    input  wire logic          i_m_tvalid,
    input  wire logic          i_m_tready,
    input  wire logic [103:0]  i_m_tdata,    // popped, top, min, empty, status
    output int                 o_fail_count,
    output int                 o_pending
);

    import mts_pkg::*;

    logic signed [DATA_W-1:0] value_col [DEPTH];
    logic signed [DATA_W-1:0] min_col [DEPTH];
    int                       entries;
    t_result                  predicted_results [$];
    int                       mismatches = 0;

    function automatic t_result apply_stack_op(input logic [1:0] act,
                                               input logic signed [DATA_W-1:0] val);
        t_result r;
        r.popped_value = ALL_ONES;
        r.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                if (entries == DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    value_col[entries] = val;
                    min_col[entries] = val;
                    if (entries > 0) begin
                        if (min_col[entries - 1] < val)
                            min_col[entries] = min_col[entries - 1];
                    end
                    entries++;
                end
            end
            ACT_POP: begin
                if (entries == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    entries--;
                    r.popped_value = value_col[entries];
                end
            end
            default: begin
                // peek, and the spare code behaves the same
                if (entries == 0)
                    r.status = ST_UNDERFLOW;
            end
        endcase
        if (entries == 0) begin
            r.top_value = ALL_ONES;
            r.min_value = ALL_ONES;
            r.empty_res = 1'b1;
        end else begin
            r.top_value = value_col[entries - 1];
            r.min_value = min_col[entries - 1];
            r.empty_res = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %h, got %h", field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            entries = 0;
            predicted_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[98:0];
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected word", '0, got.popped_value);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.popped_value !== want.popped_value)
                        report_mismatch("popped_value", want.popped_value, got.popped_value);
                    if (got.top_value !== want.top_value)
                        report_mismatch("top_value", want.top_value, got.top_value);
                    if (got.min_value !== want.min_value)
                        report_mismatch("min_value", want.min_value, got.min_value);
                    if (got.empty_res !== want.empty_res)
                        report_mismatch("empty_res", 32'(want.empty_res),
                                        32'(got.empty_res));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(got.status));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predicted_results.push_back(apply_stack_op(i_s_tdata[1:0], i_s_tdata[33:2]));
        end
        o_fail_count <= mismatches;
        o_pending <= predicted_results.size();
    end

endmodule

`default_nettype wire

// ===== bench/min_tracking_stack_core_test.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_core_test
// drives push, pop and peek words into the min tracking stack: a directed
// pass over empty, equal and extreme values, then random fill and drain runs
// that reach overflow and underflow under three idling mixes and long output
// stalls; the checker beside the block predicts and compares every word
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_core_test;

    import mts_pkg::*;

    localparam int         STACK_DEPTH  = 64;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         HOLD_AT      = 150;
    localparam int         PHASE_WORDS  = 430;
    localparam logic [1:0] ACT_SPARE    = 2'd3;
    localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    logic [39:0]   i_s_axis_tdata = '0;     // action, value
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    logic [103:0]  o_m_axis_tdata;          // popped, top, min, empty, status

    int fail_count;
    int pending;
    int tx_idle_pct = 16;
    int rx_idle_pct = 81;
    int hold_requests = 0;

    min_tracking_stack_core #(
        .DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    min_tracking_stack_checker #(
        .DEPTH(STACK_DEPTH)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // output side, with a long hold whenever one is requested
    initial begin : rx_driver
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic [1:0] act, input logic [31:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {6'b0, val, act};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2, 3, 4: return $urandom_range(6) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    // runs of fill, drain or mixed bias so the stack hits both full and empty
    task automatic run_random(input int count);
        int run_left;
        int push_pct;
        int pop_pct;
        int pick;
        logic [1:0] act;
        run_left = 0;
        push_pct = 0;
        pop_pct = 0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(120, 40);
                case ($urandom_range(2))
                    0: begin
                        push_pct = 85;
                        pop_pct = 10;
                    end
                    1: begin
                        push_pct = 10;
                        pop_pct = 85;
                    end
                    default: begin
                        push_pct = 45;
                        pop_pct = 45;
                    end
                endcase
            end
            run_left--;
            if (n == HOLD_AT)
                hold_requests <= hold_requests + 1;
            pick = $urandom_range(99);
            if (pick < push_pct)
                act = ACT_PUSH;
            else if (pick < push_pct + pop_pct)
                act = ACT_POP;
            else
                act = $urandom_range(1) ? ACT_PEEK : ACT_SPARE;
            send_word(act, pick_value());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack, equal and extreme values, then drain past empty
        send_word(ACT_POP, $urandom);
        send_word(ACT_PEEK, $urandom);
        send_word(ACT_SPARE, $urandom);
        send_word(ACT_PUSH, VAL_MAX);
        send_word(ACT_PUSH, 32'd5);
        send_word(ACT_PUSH, 32'd5);
        send_word(ACT_PUSH, -32'sd7);
        send_word(ACT_PUSH, VAL_MIN);
        send_word(ACT_PUSH, VAL_MIN);
        send_word(ACT_PUSH, 32'd0);
        send_word(ACT_PUSH, '1);
        send_word(ACT_PEEK, $urandom);
        send_word(ACT_SPARE, $urandom);
        repeat (9) send_word(ACT_POP, $urandom);
        send_word(ACT_PEEK, $urandom);

        run_random(PHASE_WORDS);
        tx_idle_pct = 81;
        rx_idle_pct = 16;
        run_random(PHASE_WORDS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_WORDS);

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
